// File: design/wait_for_graph_deadlock_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_UNIT_DEFINES_SVH
`define WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define WFGDD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WFGDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wfgdd_pkg.sv
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector: package
// Sizes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wfgdd_pkg;

  // Graph size and fixed field widths
  localparam int NODE_COUNT = 16;
  localparam int FIELD_W    = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef logic [NODE_COUNT-1:0] node_vec_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // apply edge update, mark all nodes live
    logic step;   // one peeling iteration
    logic load;   // capture the verdict into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stable; // the live set no longer shrinks
  } dp_sts_t;

endpackage

// File: design/wfgdd_ctrl.sv
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector: controller
// Sequences accept, iterative peeling and result hand-off.
// ----------------------------------------------------------------------------
module wfgdd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output wfgdd_pkg::dp_cmd_t dp_cmd,
  input  wfgdd_pkg::dp_sts_t dp_sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEL,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    dp_cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dp_cmd.start = 1'b1;
          state_nxt    = S_PEEL;
        end
      end
      S_PEEL: begin
        if (!dp_sts.stable) begin
          dp_cmd.step = 1'b1;
        end else if (slot_free) begin
          dp_cmd.load   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          dp_cmd.load   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/wfgdd_dp.sv
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector: datapath
// Adjacency matrix, live-node set peeled one iteration per cycle, verdict.
// ----------------------------------------------------------------------------
module wfgdd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear_all,
  input  logic [wfgdd_pkg::FIELD_W-1:0] from_node,
  input  logic [wfgdd_pkg::FIELD_W-1:0] to_node,
  input  logic                         edge_present,
  input  wfgdd_pkg::dp_cmd_t            dp_cmd,
  output wfgdd_pkg::dp_sts_t            dp_sts,
  output logic                         deadlock
);

  wfgdd_pkg::node_vec_t rows_r [wfgdd_pkg::NODE_COUNT];
  wfgdd_pkg::node_vec_t alive_r, alive_nxt;
  wfgdd_pkg::node_vec_t from_dec, to_dec;
  logic                 deadlock_r;

  // Decode edge endpoints; out-of-range indices match no node
  always_comb begin
    for (int n = 0; n < wfgdd_pkg::NODE_COUNT; n++) begin
      from_dec[n] = (32'(from_node) == n);
      to_dec[n]   = (32'(to_node) == n);
    end
  end

  // Drop each live node whose row has no edge into the live set
  always_comb begin
    for (int n = 0; n < wfgdd_pkg::NODE_COUNT; n++) begin
      alive_nxt[n] = alive_r[n] && ((rows_r[n] & alive_r) != '0);
    end
  end

  assign dp_sts.stable = (alive_nxt == alive_r);

  // Update the matrix on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < wfgdd_pkg::NODE_COUNT; r++) begin
        rows_r[r] <= '0;
      end
    end else if (dp_cmd.start) begin
      for (int r = 0; r < wfgdd_pkg::NODE_COUNT; r++) begin
        if (clear_all) begin
          rows_r[r] <= '0;
        end else if (from_dec[r]) begin
          for (int c = 0; c < wfgdd_pkg::NODE_COUNT; c++) begin
            if (to_dec[c]) begin
              rows_r[r][c] <= edge_present;
            end
          end
        end
      end
    end
  end

  // Advance the live set and capture the verdict
  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      alive_r <= '1;
    end else if (dp_cmd.step) begin
      alive_r <= alive_nxt;
    end
    if (dp_cmd.load) begin
      deadlock_r <= (alive_r != '0);
    end
  end

  assign deadlock = deadlock_r;

endmodule

// File: design/wait_for_graph_deadlock_detector_unit.sv
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector
// Keeps a wait-for graph and reports after every edge update or clear
// whether it holds a directed cycle.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                       Contents
// in       in   in_tvalid/tready/tdata/tuser  edge update or clear request
// out      out  out_tvalid/tready/tdata       deadlock verdict, one per request
//
// An item runs k peeling iterations (0 to NODE_COUNT), one live-set
// iteration per cycle; the chain length of acyclic waiters sets k.
// Reset (rst_n low, synchronous) clears the graph and the control state.
// A new request is taken while a verdict still waits in the output register;
// a finished verdict stalls the block only while that register stays full.
// ----------------------------------------------------------------------------
`include "wait_for_graph_deadlock_detector_unit_defines.svh"

module wait_for_graph_deadlock_detector_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] from_node, [7:4] to_node, [8] edge_present, [15:9] zero
  input  logic [wfgdd_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] clear_all
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] deadlock, [7:1] zero
  output logic [wfgdd_pkg::OUT_DATA_W-1:0] out_tdata
);

  wfgdd_pkg::dp_cmd_t dp_cmd;
  wfgdd_pkg::dp_sts_t dp_sts;
  logic               deadlock;

  wfgdd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts)
  );

  wfgdd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear_all    (in_tuser),
    .from_node    (in_tdata[wfgdd_pkg::FIELD_W-1:0]),
    .to_node      (in_tdata[2*wfgdd_pkg::FIELD_W-1:wfgdd_pkg::FIELD_W]),
    .edge_present (in_tdata[2*wfgdd_pkg::FIELD_W]),
    .dp_cmd       (dp_cmd),
    .dp_sts       (dp_sts),
    .deadlock     (deadlock)
  );

  assign out_tdata = {{(wfgdd_pkg::OUT_DATA_W-1){1'b0}}, deadlock};

  // Checks on the sequencing
  `WFGDD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `WFGDD_ASSERT_IMPL(a_step_while_busy, dp_cmd.step || dp_cmd.load, !in_tready, "work while idle")
  `WFGDD_ASSERT_IMPL(a_load_slot_free, dp_cmd.load, !out_tvalid || out_tready, "verdict overwritten")
  `WFGDD_ASSERT_IMPL(a_rise_from_load, $rose(out_tvalid), $past(dp_cmd.load), "valid without load")

endmodule

// File: tb/wait_for_graph_deadlock_detector_unit_test.sv
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector: block-level test
// Drives edge updates and clears into the detector, keeps a shadow copy of
// the wait-for graph, and checks every deadlock verdict against a cycle
// search on that shadow graph. Both stream sides idle at random, and the
// result side holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQUEST_TOTAL = 500;
  localparam int CALM_TAIL     = 80;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int LONG_HOLD     = 250;
  localparam int HOLD_AT       = 40;
  localparam int DRAIN_CYCLES  = 2 * (wfgdd_pkg::NODE_COUNT + 3);
  localparam int MAX_REPORTS   = 10;

  // Shadow wait-for graph and the queue of verdicts it predicts
  class wait_graph_model;
    wfgdd_pkg::node_vec_t wait_rows [wfgdd_pkg::NODE_COUNT];
    bit        expected_verdicts [$];
    int        errors;

    function new();
      foreach (wait_rows[i]) wait_rows[i] = '0;
      errors = 0;
    endfunction

    // Peel off nodes that wait on no live node; whatever survives is on a cycle or waits on one
    function bit holds_cycle();
      wfgdd_pkg::node_vec_t live;
      bit        shrunk;
      live = '1;
      do begin
        shrunk = 0;
        for (int n = 0; n < wfgdd_pkg::NODE_COUNT; n++) begin
          if (live[n] && (wait_rows[n] & live) == '0) begin
            live[n] = 1'b0;
            shrunk  = 1;
          end
        end
      end while (shrunk);
      return live != '0;
    endfunction

    // Apply an accepted request and queue the verdict it must produce
    function void note_request(bit clear_all, bit [wfgdd_pkg::FIELD_W-1:0] from_node,
                               bit [wfgdd_pkg::FIELD_W-1:0] to_node, bit edge_present);
      if (clear_all) begin
        foreach (wait_rows[i]) wait_rows[i] = '0;
      end else begin
        wait_rows[from_node][to_node] = edge_present;
      end
      expected_verdicts.push_back(holds_cycle());
    endfunction

    // Compare one delivered verdict with the oldest prediction
    function void check_verdict(logic [wfgdd_pkg::OUT_DATA_W-1:0] verdict_word);
      bit want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("verdict 0x%02h arrived with no request outstanding", verdict_word);
        return;
      end
      want = expected_verdicts.pop_front();
      if (verdict_word !== {{(wfgdd_pkg::OUT_DATA_W-1){1'b0}}, want}) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("verdict mismatch: expected deadlock=%0b, got out_tdata=0x%02h",
                   want, verdict_word);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [wfgdd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [wfgdd_pkg::OUT_DATA_W-1:0] out_tdata;

  wait_graph_model graph_model;
  int              requests_sent;
  int              verdicts_seen;
  bit              calm;
  int              quiet_cycles;

  wait_for_graph_deadlock_detector_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the sender for a random burst, one low cycle at a time
  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Offer one request and hold it until the block takes the transfer
  task automatic send_request(input bit clear_all,
                              input bit [wfgdd_pkg::FIELD_W-1:0] from_node,
                              input bit [wfgdd_pkg::FIELD_W-1:0] to_node,
                              input bit edge_present);
    if (!calm && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 15));
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= clear_all;
    in_tdata  <= {{(wfgdd_pkg::IN_DATA_W-2*wfgdd_pkg::FIELD_W-1){1'b0}},
                  edge_present, to_node, from_node};
    do @(posedge clk); while (!in_tready);
    graph_model.note_request(clear_all, from_node, to_node, edge_present);
    requests_sent++;
    if (requests_sent >= REQUEST_TOTAL - CALM_TAIL) calm = 1;
  endtask

  // Build a waiter chain over k distinct nodes, maybe close it, maybe break it
  task automatic run_chain_episode();
    int              order [wfgdd_pkg::NODE_COUNT];
    int              k;
    int              j;
    int              tmp;
    int              cut;
    bit              closed;
    for (int i = 0; i < wfgdd_pkg::NODE_COUNT; i++) order[i] = i;
    for (int i = wfgdd_pkg::NODE_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(9, wfgdd_pkg::NODE_COUNT)
                                    : $urandom_range(1, 8);
    if ($urandom_range(0, 1)) send_request(1'b1, 4'($urandom), 4'($urandom), 1'($urandom));
    for (int i = 0; i + 1 < k; i++) send_request(1'b0, 4'(order[i]), 4'(order[i+1]), 1'b1);
    closed = $urandom_range(0, 1);
    if (closed) send_request(1'b0, 4'(order[k-1]), 4'(order[0]), 1'b1);
    // Hang a few stray waiters off the structure
    repeat ($urandom_range(0, 3))
      send_request(1'b0, 4'($urandom), 4'(order[$urandom_range(0, k-1)]), 1'b1);
    if (closed && $urandom_range(0, 1)) begin
      cut = $urandom_range(0, k - 1);
      send_request(1'b0, 4'(order[cut]), 4'(order[(cut + 1) % k]), 1'b0);
    end
  endtask

  // Sender: reset, directed cases, then chain episodes mixed with noise
  initial begin
    graph_model   = new();
    requests_sent = 0;
    calm          = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Self edges at both index extremes, and removal of each
    send_request(1'b0, 4'd0, 4'd0, 1'b1);
    send_request(1'b0, 4'd0, 4'd0, 1'b0);
    send_request(1'b0, 4'd15, 4'd15, 1'b1);
    send_request(1'b0, 4'd15, 4'd15, 1'b0);
    // Remove an edge that was never there
    send_request(1'b0, 4'd7, 4'd9, 1'b0);
    // Two-node cycle across the extremes, added twice, then broken
    send_request(1'b0, 4'd15, 4'd0, 1'b1);
    send_request(1'b0, 4'd15, 4'd0, 1'b1);
    send_request(1'b0, 4'd0, 4'd15, 1'b1);
    send_request(1'b0, 4'd15, 4'd0, 1'b0);
    // Clear with every other field set, then with all fields zero
    send_request(1'b1, 4'd15, 4'd15, 1'b1);
    send_request(1'b0, 4'd3, 4'd3, 1'b1);
    send_request(1'b1, 4'd0, 4'd0, 1'b0);
    // Longest chain, closed into a full ring, then reopened in the middle
    for (int n = 0; n < wfgdd_pkg::NODE_COUNT - 1; n++)
      send_request(1'b0, 4'(n), 4'(n + 1), 1'b1);
    send_request(1'b0, 4'd15, 4'd0, 1'b1);
    send_request(1'b0, 4'd7, 4'd8, 1'b0);
    send_request(1'b1, 4'd0, 4'd0, 1'b0);

    // Random part
    while (requests_sent < REQUEST_TOTAL) begin
      if ($urandom_range(0, 3) != 0) begin
        run_chain_episode();
      end else begin
        repeat ($urandom_range(3, 12))
          send_request($urandom_range(0, 19) == 0, 4'($urandom), 4'($urandom),
                       1'($urandom));
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain outstanding verdicts, then let the block settle
    while (graph_model.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (graph_model.errors == 0)
      $display("wait_for_graph_deadlock_detector_unit_test: done, clean");
    else
      $display("wait_for_graph_deadlock_detector_unit_test: done, errors");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, check each transfer
  initial begin
    int  stall_left;
    bit  hold_done;
    stall_left    = 0;
    hold_done     = 0;
    verdicts_seen = 0;
    out_tready    = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && verdicts_seen >= HOLD_AT) begin
        hold_done  = 1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        graph_model.check_verdict(out_tdata);
        verdicts_seen++;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("wait_for_graph_deadlock_detector_unit_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
